/* design/cbrs_pkg.sv */
// Package for the crop bilinear RGB scaler: parameter defaults, register
// indexes, source format codes and the pixel decode function.
// No dependencies.
`default_nettype none

package cbrs_pkg;

   localparam int MAX_LINE_PIXELS_DEF = 1024;
   localparam int POS_FRAC_BITS_DEF   = 16;
   localparam int WEIGHT_BITS_DEF     = 8;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int DIM_REG_W  = 11;
   localparam int FMT_REG_W  = 2;
   localparam int PIXEL_W    = 24;
   localparam int COORD_W    = 10;
   localparam int CHAN_W     = 8;

   localparam logic [2:0] REG_SRC_W  = 3'd0;
   localparam logic [2:0] REG_SRC_H  = 3'd1;
   localparam logic [2:0] REG_FORMAT = 3'd2;
   localparam logic [2:0] REG_DST_W  = 3'd3;
   localparam logic [2:0] REG_DST_H  = 3'd4;

   localparam logic [DIM_REG_W-1:0] RST_SRC_W  = 11'd320;
   localparam logic [DIM_REG_W-1:0] RST_SRC_H  = 11'd240;
   localparam logic [FMT_REG_W-1:0] RST_FORMAT = 2'd0;
   localparam logic [DIM_REG_W-1:0] RST_DST_W  = 11'd96;
   localparam logic [DIM_REG_W-1:0] RST_DST_H  = 11'd96;

   localparam logic [FMT_REG_W-1:0] FMT_565_LE = 2'd0;
   localparam logic [FMT_REG_W-1:0] FMT_565_BE = 2'd1;
   localparam logic [FMT_REG_W-1:0] FMT_RGB24  = 2'd2;

   localparam logic [4:0] MASK5 = 5'h1f;
   localparam logic [5:0] MASK6 = 6'h3f;

   // expand a raw word to RGB888; unknown format reads as black
   function automatic logic [PIXEL_W-1:0] decode_pixel(input logic [PIXEL_W-1:0] w,
                                                       input logic [FMT_REG_W-1:0] fmt);
      logic [15:0] v;
      logic [4:0]  r5;
      logic [5:0]  g6;
      logic [4:0]  b5;
      logic [PIXEL_W-1:0] res;
      v   = 16'd0;
      res = '0;
      case (fmt)
         FMT_565_LE: v = {w[7:0], w[15:8]};
         FMT_565_BE: v = w[15:0];
         default:    v = 16'd0;
      endcase
      r5 = v[15:11] & MASK5;
      g6 = v[10:5] & MASK6;
      b5 = v[4:0] & MASK5;
      case (fmt)
         FMT_RGB24:  res = w;
         FMT_565_LE,
         FMT_565_BE: res = {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};
         default:    res = '0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

/* design/crop_bilinear_rgb_scaler.sv */
// An input item yields n results (0..4). A frame_begin beat first runs the
// crop and step divisions on one radix-2 divider (quotient width
// NW = max(2*DW, DW+F), 27 at defaults). Reset is synchronous, active high;
// after release the crop geometry is worked out with zero steps (req_ready
// low meanwhile).
// Top level of the crop bilinear RGB scaler; uses cbrs_pkg.
`default_nettype none

module crop_bilinear_rgb_scaler #(
   parameter int MAX_LINE_PIXELS        = cbrs_pkg::MAX_LINE_PIXELS_DEF,
   parameter int POSITION_FRACTION_BITS = cbrs_pkg::POS_FRAC_BITS_DEF,
   parameter int WEIGHT_BITS            = cbrs_pkg::WEIGHT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [cbrs_pkg::PIXEL_W-1:0]        req_pixel_word,
   input  wire logic                                req_frame_begin,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [cbrs_pkg::CHAN_W-1:0]              rsp_red,
   output logic [cbrs_pkg::CHAN_W-1:0]              rsp_green,
   output logic [cbrs_pkg::CHAN_W-1:0]              rsp_blue,
   output logic [cbrs_pkg::COORD_W-1:0]             rsp_target_column,
   output logic [cbrs_pkg::COORD_W-1:0]             rsp_target_row,
   output logic                                     rsp_last_of_run,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [cbrs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [cbrs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cbrs_pkg::CSR_DATA_W-1:0]          prdata,
   output logic                                     pready
);

   localparam int F    = POSITION_FRACTION_BITS;
   localparam int W    = WEIGHT_BITS;
   localparam int DW   = $clog2(MAX_LINE_PIXELS + 1);
   localparam int AW   = $clog2(MAX_LINE_PIXELS);
   localparam int NW   = (2 * DW > DW + F) ? 2 * DW : DW + F;
   localparam int PW   = DW + F + 3;
   localparam int CNTW = $clog2(NW + 1);
   localparam int TW   = W + 9;
   localparam int VW   = 2 * W + 11;

   typedef struct packed {
      logic [DW-1:0] trig;
      logic [W-1:0]  wt;
      logic          single;
   } pick_type;

   typedef enum logic [4:0] {
      S_GLATCH, S_GDIV1, S_GWAIT1, S_GDIV2, S_GWAIT2, S_GDIV3, S_GWAIT3,
      S_GDIV4, S_GWAIT4, S_GBASE, S_IDLE, S_READ, S_PICK, S_MUL1, S_MUL2,
      S_OUT, S_UPDATE
   } state_type;

   // configuration registers
   logic [cbrs_pkg::DIM_REG_W-1:0] src_w_csr_ff, src_h_csr_ff, dst_w_csr_ff, dst_h_csr_ff;
   logic [cbrs_pkg::FMT_REG_W-1:0] format_csr_ff;
   logic                           csr_write;
   logic [2:0]                     csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[4:2];
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_csr_ff  <= cbrs_pkg::RST_SRC_W;
         src_h_csr_ff  <= cbrs_pkg::RST_SRC_H;
         format_csr_ff <= cbrs_pkg::RST_FORMAT;
         dst_w_csr_ff  <= cbrs_pkg::RST_DST_W;
         dst_h_csr_ff  <= cbrs_pkg::RST_DST_H;
      end else if (csr_write) begin
         case (csr_index)
            cbrs_pkg::REG_SRC_W:  src_w_csr_ff  <= pwdata[cbrs_pkg::DIM_REG_W-1:0];
            cbrs_pkg::REG_SRC_H:  src_h_csr_ff  <= pwdata[cbrs_pkg::DIM_REG_W-1:0];
            cbrs_pkg::REG_FORMAT: format_csr_ff <= pwdata[cbrs_pkg::FMT_REG_W-1:0];
            cbrs_pkg::REG_DST_W:  dst_w_csr_ff  <= pwdata[cbrs_pkg::DIM_REG_W-1:0];
            cbrs_pkg::REG_DST_H:  dst_h_csr_ff  <= pwdata[cbrs_pkg::DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cbrs_pkg::REG_SRC_W:  prdata = 32'(src_w_csr_ff);
         cbrs_pkg::REG_SRC_H:  prdata = 32'(src_h_csr_ff);
         cbrs_pkg::REG_FORMAT: prdata = 32'(format_csr_ff);
         cbrs_pkg::REG_DST_W:  prdata = 32'(dst_w_csr_ff);
         cbrs_pkg::REG_DST_H:  prdata = 32'(dst_h_csr_ff);
         default:              prdata = '0;
      endcase
   end

   // zero counts as one, oversize saturates at the line store depth
   function automatic logic [DW-1:0] clamp_dim(input logic [cbrs_pkg::DIM_REG_W-1:0] v);
      logic [15:0] v16;
      logic [15:0] r16;
      v16 = 16'(v);
      if (v16 == 16'd0) r16 = 16'd1;
      else if (v16 > 16'(MAX_LINE_PIXELS)) r16 = 16'(MAX_LINE_PIXELS);
      else r16 = v16;
      return r16[DW-1:0];
   endfunction

   function automatic pick_type pick_axis(input logic signed [PW-1:0] pos,
                                          input logic [DW-1:0] dim);
      logic [PW-F-1:0] ipos;
      logic [F-1:0]    frac;
      logic [PW-F:0]   ip1;
      logic [F+W-1:0]  fw;
      pick_type        p;
      ipos = '0;
      frac = '0;
      if (!pos[PW-1] && pos != '0) begin
         ipos = pos[PW-1:F];
         frac = pos[F-1:0];
      end
      ip1 = {1'b0, ipos} + (PW-F+1)'(1);
      fw  = {frac, {W{1'b0}}} >> F;
      if (ip1 >= (PW-F+1)'(dim)) begin
         p.trig   = dim - DW'(1);
         p.wt     = '0;
         p.single = 1'b1;
      end else begin
         p.trig   = ip1[DW-1:0];
         p.wt     = fw[W-1:0];
         p.single = 1'b0;
      end
      return p;
   endfunction

   state_type state_ff;

   // latched geometry
   logic [DW-1:0]          sw_ff, sh_ff, tw_ff, th_ff, crop_w_ff, crop_h_ff;
   logic signed [PW-1:0]   cstep_ff, rstep_ff, cbase_ff, rbase_ff, cpos_ff, rpos_ff;
   logic                   with_steps_ff, item_pend_ff;

   // stream position
   logic [AW-1:0]          sc_ff;
   logic [DW-1:0]          sr_ff, tcc_ff, trc_ff;
   logic [cbrs_pkg::PIXEL_W-1:0] cur_ff, above_ff, above_left_ff, current_left_ff;
   logic [cbrs_pkg::PIXEL_W-1:0] mem_q_ff;

   // divider
   logic [NW-1:0]   div_quo_ff;
   logic [DW-1:0]   div_rem_ff, div_den_ff;
   logic [CNTW-1:0] div_cnt_ff;
   logic [DW:0]     rem_sh, rem_sub;
   logic            rem_ge;
   logic [DW-1:0]   div_rem_in;
   logic [NW-1:0]   div_quo_in;

   assign rem_sh     = {div_rem_ff, div_quo_ff[NW-1]};
   assign rem_ge     = rem_sh >= {1'b0, div_den_ff};
   assign rem_sub    = rem_sh - {1'b0, div_den_ff};
   assign div_rem_in = rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
   assign div_quo_in = {div_quo_ff[NW-2:0], rem_ge};

   // per-item picks
   logic [1:0]    nr_ff, nc_ff;
   logic [W-1:0]  wy_ff [2];
   logic [W-1:0]  wx_ff [2];
   logic [1:0]    rs_ff, cs_ff;
   logic          ri_ff, ci_ff;

   pick_type rp0, rp1, cp0, cp1;
   logic     row0, row1, col0, col1;
   logic [DW:0] trc_p1, tcc_p1;

   always_comb begin
      rp0    = pick_axis(rpos_ff, sh_ff);
      rp1    = pick_axis(rpos_ff + rstep_ff, sh_ff);
      cp0    = pick_axis(cpos_ff, sw_ff);
      cp1    = pick_axis(cpos_ff + cstep_ff, sw_ff);
      trc_p1 = {1'b0, trc_ff} + (DW+1)'(1);
      tcc_p1 = {1'b0, tcc_ff} + (DW+1)'(1);
      row0   = (trc_ff < th_ff) && (rp0.trig <= sr_ff);
      row1   = row0 && (trc_p1 < {1'b0, th_ff}) && (rp1.trig <= sr_ff);
      col0   = (tcc_ff < tw_ff) && (cp0.trig <= DW'(sc_ff));
      col1   = col0 && (tcc_p1 < {1'b0, tw_ff}) && (cp1.trig <= DW'(sc_ff));
   end

   // neighbor selection and blend
   logic [cbrs_pkg::PIXEL_W-1:0] p00, p01, p10, p11;
   logic [W-1:0]  wx, wy;
   logic [W:0]    smx, smy;
   logic [TW-1:0] top_in [3];
   logic [TW-1:0] bot_in [3];
   logic [TW-1:0] top_ff [3];
   logic [TW-1:0] bot_ff [3];
   logic [VW-1:0] v_in [3];

   always_comb begin
      p11 = cur_ff;
      p10 = cs_ff[ci_ff] ? cur_ff : current_left_ff;
      if (rs_ff[ri_ff]) begin
         p00 = p10;
         p01 = cur_ff;
      end else begin
         p00 = cs_ff[ci_ff] ? above_ff : above_left_ff;
         p01 = above_ff;
      end
      wx  = wx_ff[ci_ff];
      wy  = wy_ff[ri_ff];
      smx = (W+1)'(1 << W) - (W+1)'(wx);
      smy = (W+1)'(1 << W) - (W+1)'(wy);
      for (int k = 0; k < 3; k++) begin
         top_in[k] = TW'(p00[8*(2-k)+:8]) * TW'(smx) + TW'(p01[8*(2-k)+:8]) * TW'(wx);
         bot_in[k] = TW'(p10[8*(2-k)+:8]) * TW'(smx) + TW'(p11[8*(2-k)+:8]) * TW'(wx);
         v_in[k]   = VW'(top_ff[k]) * VW'(smy) + VW'(bot_ff[k]) * VW'(wy)
                   + (VW'(1) << (2 * W - 1));
      end
   end

   logic [15:0] dx16, dy16;
   logic        last_in;
   assign dx16    = 16'(tcc_ff) + 16'(ci_ff);
   assign dy16    = 16'(trc_ff) + 16'(ri_ff);
   assign last_in = ({1'b0, ri_ff} + 2'd1 == nr_ff) && ({1'b0, ci_ff} + 2'd1 == nc_ff);

   // geometry base values
   logic [PW-1:0] cdiff, rdiff, half;
   logic signed [PW-1:0] cbase_in, rbase_in;
   always_comb begin
      cdiff    = (PW'(sw_ff - crop_w_ff) << F) >> 1;
      rdiff    = (PW'(sh_ff - crop_h_ff) << F) >> 1;
      half     = PW'(1) << (F - 1);
      cbase_in = $signed(cdiff) + (cstep_ff >>> 1) - $signed(half);
      rbase_in = $signed(rdiff) + (rstep_ff >>> 1) - $signed(half);
   end

   logic [AW:0] sc_p1;
   assign sc_p1 = {1'b0, sc_ff} + (AW+1)'(1);

   // line store: one write port, one registered read port
   logic [cbrs_pkg::PIXEL_W-1:0] line_mem [MAX_LINE_PIXELS];
   logic mem_we;
   assign mem_we = (state_ff == S_UPDATE);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[sc_ff] <= cur_ff;
      end
      mem_q_ff <= line_mem[sc_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_GLATCH;
         with_steps_ff   <= 1'b0;
         item_pend_ff    <= 1'b0;
         rsp_valid       <= 1'b0;
         above_left_ff   <= '0;
         current_left_ff <= '0;
         sc_ff           <= '0;
         sr_ff           <= '0;
         tcc_ff          <= '0;
         trc_ff          <= '0;
      end else begin
         case (state_ff)
            S_GLATCH: begin
               sw_ff    <= clamp_dim(src_w_csr_ff);
               sh_ff    <= clamp_dim(src_h_csr_ff);
               tw_ff    <= clamp_dim(dst_w_csr_ff);
               th_ff    <= clamp_dim(dst_h_csr_ff);
               state_ff <= S_GDIV1;
            end
            S_GDIV1: begin
               div_quo_ff <= NW'(sw_ff) * NW'(th_ff);
               div_den_ff <= tw_ff;
               div_rem_ff <= '0;
               div_cnt_ff <= CNTW'(NW);
               state_ff   <= S_GWAIT1;
            end
            S_GWAIT1: begin
               if (div_cnt_ff != '0) begin
                  div_quo_ff <= div_quo_in;
                  div_rem_ff <= div_rem_in;
                  div_cnt_ff <= div_cnt_ff - CNTW'(1);
               end else if (div_quo_ff > NW'(sh_ff)) begin
                  crop_h_ff <= sh_ff;
                  state_ff  <= S_GDIV2;
               end else begin
                  crop_h_ff <= div_quo_ff[DW-1:0];
                  crop_w_ff <= sw_ff;
                  state_ff  <= S_GDIV3;
               end
            end
            S_GDIV2: begin
               div_quo_ff <= NW'(sh_ff) * NW'(tw_ff);
               div_den_ff <= th_ff;
               div_rem_ff <= '0;
               div_cnt_ff <= CNTW'(NW);
               state_ff   <= S_GWAIT2;
            end
            S_GWAIT2: begin
               if (div_cnt_ff != '0) begin
                  div_quo_ff <= div_quo_in;
                  div_rem_ff <= div_rem_in;
                  div_cnt_ff <= div_cnt_ff - CNTW'(1);
               end else begin
                  crop_w_ff <= div_quo_ff[DW-1:0];
                  state_ff  <= S_GDIV3;
               end
            end
            S_GDIV3: begin
               if (with_steps_ff) begin
                  div_quo_ff <= NW'(crop_w_ff) << F;
                  div_den_ff <= tw_ff;
                  div_rem_ff <= '0;
                  div_cnt_ff <= CNTW'(NW);
                  state_ff   <= S_GWAIT3;
               end else begin
                  cstep_ff <= '0;
                  rstep_ff <= '0;
                  state_ff <= S_GBASE;
               end
            end
            S_GWAIT3: begin
               if (div_cnt_ff != '0) begin
                  div_quo_ff <= div_quo_in;
                  div_rem_ff <= div_rem_in;
                  div_cnt_ff <= div_cnt_ff - CNTW'(1);
               end else begin
                  cstep_ff <= $signed(PW'(div_quo_ff[DW+F-1:0]));
                  state_ff <= S_GDIV4;
               end
            end
            S_GDIV4: begin
               div_quo_ff <= NW'(crop_h_ff) << F;
               div_den_ff <= th_ff;
               div_rem_ff <= '0;
               div_cnt_ff <= CNTW'(NW);
               state_ff   <= S_GWAIT4;
            end
            S_GWAIT4: begin
               if (div_cnt_ff != '0) begin
                  div_quo_ff <= div_quo_in;
                  div_rem_ff <= div_rem_in;
                  div_cnt_ff <= div_cnt_ff - CNTW'(1);
               end else begin
                  rstep_ff <= $signed(PW'(div_quo_ff[DW+F-1:0]));
                  state_ff <= S_GBASE;
               end
            end
            S_GBASE: begin
               cbase_ff <= cbase_in;
               rbase_ff <= rbase_in;
               cpos_ff  <= cbase_in;
               rpos_ff  <= rbase_in;
               sc_ff    <= '0;
               sr_ff    <= '0;
               tcc_ff   <= '0;
               trc_ff   <= '0;
               state_ff <= item_pend_ff ? S_READ : S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  cur_ff <= cbrs_pkg::decode_pixel(req_pixel_word, format_csr_ff);
                  if (req_frame_begin) begin
                     with_steps_ff <= 1'b1;
                     item_pend_ff  <= 1'b1;
                     state_ff      <= S_GLATCH;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            S_READ: begin
               item_pend_ff <= 1'b0;
               state_ff     <= S_PICK;
            end
            S_PICK: begin
               above_ff <= mem_q_ff;
               nr_ff    <= {row0 & row1, row0 ^ row1};
               nc_ff    <= {col0 & col1, col0 ^ col1};
               wy_ff[0] <= rp0.wt;
               wy_ff[1] <= rp1.wt;
               rs_ff    <= {rp1.single, rp0.single};
               wx_ff[0] <= cp0.wt;
               wx_ff[1] <= cp1.wt;
               cs_ff    <= {cp1.single, cp0.single};
               ri_ff    <= 1'b0;
               ci_ff    <= 1'b0;
               state_ff <= (row0 && col0) ? S_MUL1 : S_UPDATE;
            end
            S_MUL1: begin
               top_ff   <= top_in;
               bot_ff   <= bot_in;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               rsp_red           <= v_in[0][2*W+7:2*W];
               rsp_green         <= v_in[1][2*W+7:2*W];
               rsp_blue          <= v_in[2][2*W+7:2*W];
               rsp_target_column <= dx16[cbrs_pkg::COORD_W-1:0];
               rsp_target_row    <= dy16[cbrs_pkg::COORD_W-1:0];
               rsp_last_of_run   <= last_in;
               rsp_valid         <= 1'b1;
               state_ff          <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  if ({1'b0, ci_ff} + 2'd1 < nc_ff) begin
                     ci_ff    <= 1'b1;
                     state_ff <= S_MUL1;
                  end else if ({1'b0, ri_ff} + 2'd1 < nr_ff) begin
                     ri_ff    <= 1'b1;
                     ci_ff    <= 1'b0;
                     state_ff <= S_MUL1;
                  end else begin
                     state_ff <= S_UPDATE;
                  end
               end
            end
            S_UPDATE: begin
               above_left_ff   <= above_ff;
               current_left_ff <= cur_ff;
               if ({1'b0, sc_p1} >= (AW+2)'(sw_ff)) begin
                  trc_ff <= trc_ff + DW'(nr_ff);
                  case (nr_ff)
                     2'd1:    rpos_ff <= rpos_ff + rstep_ff;
                     2'd2:    rpos_ff <= rpos_ff + (rstep_ff <<< 1);
                     default: ;
                  endcase
                  tcc_ff  <= '0;
                  cpos_ff <= cbase_ff;
                  sc_ff   <= '0;
                  if (sr_ff < sh_ff) sr_ff <= sr_ff + DW'(1);
               end else begin
                  tcc_ff <= tcc_ff + DW'(nc_ff);
                  case (nc_ff)
                     2'd1:    cpos_ff <= cpos_ff + cstep_ff;
                     2'd2:    cpos_ff <= cpos_ff + (cstep_ff <<< 1);
                     default: ;
                  endcase
                  sc_ff <= sc_p1[AW-1:0];
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

/* design/cbrs_check.sv */
// Port-level checker for the crop bilinear RGB scaler, bound to the top level.
// Depends on cbrs_pkg for field widths.
`default_nettype none

module cbrs_check (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [cbrs_pkg::CHAN_W-1:0]     rsp_red,
   input wire logic [cbrs_pkg::CHAN_W-1:0]     rsp_green,
   input wire logic [cbrs_pkg::CHAN_W-1:0]     rsp_blue,
   input wire logic [cbrs_pkg::COORD_W-1:0]    rsp_target_column,
   input wire logic [cbrs_pkg::COORD_W-1:0]    rsp_target_row,
   input wire logic                            rsp_last_of_run
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red) && $stable(rsp_green)
         && $stable(rsp_blue) && $stable(rsp_target_column) && $stable(rsp_target_row)
         && $stable(rsp_last_of_run))
      else $error("result beat changed while stalled");

   // one item in flight: no new input while a result is shown
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accepted beat");

   // geometry pass runs after reset
   a_reset_busy: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready right after reset");

endmodule

bind crop_bilinear_rgb_scaler cbrs_check u_cbrs_check (.*);

`default_nettype wire

/* tb/tb_top.sv */
// Testbench for crop_bilinear_rgb_scaler: streams frames through the block and
// checks every destination pixel against a cycle-free scaler predictor.
// Depends on cbrs_pkg and the design top level.
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [cbrs_pkg::PIXEL_W-1:0] word;
      logic                         fb;
   } src_beat_type;

   typedef struct {
      logic [cbrs_pkg::CHAN_W-1:0]  red, green, blue;
      logic [cbrs_pkg::COORD_W-1:0] col, row;
      logic                         last;
   } dst_pixel_type;

   typedef struct {
      int unsigned trig;
      int unsigned wt;
      bit          single;
   } axis_type;

   localparam int LINE_MAX   = cbrs_pkg::MAX_LINE_PIXELS_DEF;
   localparam int FRAC       = cbrs_pkg::POS_FRAC_BITS_DEF;
   localparam int WBITS      = cbrs_pkg::WEIGHT_BITS_DEF;
   localparam int DRAIN_WAIT = 160;
   localparam int WATCHDOG   = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [cbrs_pkg::PIXEL_W-1:0] req_pixel_word = '0;
   logic req_frame_begin = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [cbrs_pkg::CHAN_W-1:0] rsp_red, rsp_green, rsp_blue;
   logic [cbrs_pkg::COORD_W-1:0] rsp_target_column, rsp_target_row;
   logic rsp_last_of_run;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [cbrs_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [cbrs_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [cbrs_pkg::CSR_DATA_W-1:0] prdata;
   logic pready;

   crop_bilinear_rgb_scaler uut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [cbrs_pkg::DIM_REG_W-1:0] reg_sw = cbrs_pkg::RST_SRC_W, reg_sh = cbrs_pkg::RST_SRC_H;
   logic [cbrs_pkg::DIM_REG_W-1:0] reg_tw = cbrs_pkg::RST_DST_W, reg_th = cbrs_pkg::RST_DST_H;
   logic [cbrs_pkg::FMT_REG_W-1:0] reg_fmt = cbrs_pkg::RST_FORMAT;
   logic [cbrs_pkg::PIXEL_W-1:0] line_mem [LINE_MAX];
   logic [cbrs_pkg::PIXEL_W-1:0] above_left, current_left;
   int unsigned src_col, src_row, dst_col_cnt, dst_row_cnt;
   int unsigned geo_sw, geo_sh, geo_tw, geo_th;
   longint col_pos, row_pos, col_step, row_step, col_base, row_base;

   src_beat_type  pending_beats[$];
   dst_pixel_type pixel_expect_q[$];
   bit failed = 1'b0;
   int send_idle_pct = 22, recv_idle_pct = 81;
   int hold_requests = 0;
   bit req_taken = 1'b0;
   int rand_items = 0;

   function automatic int unsigned clamp_dim(logic [cbrs_pkg::DIM_REG_W-1:0] v);
      if (v == 0) return 1;
      if (v > LINE_MAX) return LINE_MAX;
      return v;
   endfunction

   function automatic void latch_geometry(bit with_steps);
      longint unsigned crop_w, crop_h;
      geo_sw = clamp_dim(reg_sw);
      geo_sh = clamp_dim(reg_sh);
      geo_tw = clamp_dim(reg_tw);
      geo_th = clamp_dim(reg_th);
      crop_w = geo_sw;
      crop_h = (longint'(geo_sw) * geo_th) / geo_tw;
      if (crop_h > geo_sh) begin
         crop_h = geo_sh;
         crop_w = (longint'(geo_sh) * geo_tw) / geo_th;
      end
      col_step = with_steps ? longint'((crop_w << FRAC) / geo_tw) : 0;
      row_step = with_steps ? longint'((crop_h << FRAC) / geo_th) : 0;
      col_base = longint'(((geo_sw - crop_w) << FRAC) >> 1) + (col_step >> 1)
                 - (longint'(1) << (FRAC - 1));
      row_base = longint'(((geo_sh - crop_h) << FRAC) >> 1) + (row_step >> 1)
                 - (longint'(1) << (FRAC - 1));
      col_pos = col_base;
      row_pos = row_base;
   endfunction

   function automatic axis_type split_pos(longint pos, int unsigned dim);
      axis_type a;
      longint unsigned ip, fr;
      ip = 0;
      fr = 0;
      if (pos > 0) begin
         ip = longint'(pos) >> FRAC;
         fr = pos & ((longint'(1) << FRAC) - 1);
      end
      if (ip + 1 >= dim) begin
         a.trig = dim - 1;
         a.wt = 0;
         a.single = 1'b1;
      end else begin
         a.trig = 32'(ip + 1);
         a.wt = 32'(fr >> (FRAC - WBITS));
         a.single = 1'b0;
      end
      return a;
   endfunction

   function automatic logic [cbrs_pkg::PIXEL_W-1:0] expand_rgb(
         logic [cbrs_pkg::PIXEL_W-1:0] w);
      logic [15:0] h;
      if (reg_fmt == cbrs_pkg::FMT_RGB24) return w;
      if (reg_fmt == cbrs_pkg::FMT_565_LE) h = {w[7:0], w[15:8]};
      else if (reg_fmt == cbrs_pkg::FMT_565_BE) h = w[15:0];
      else return '0;
      return {h[15:11], h[15:13], h[10:5], h[10:9], h[4:0], h[4:2]};
   endfunction

   function automatic logic [cbrs_pkg::CHAN_W-1:0] mix_chan(logic [7:0] a, logic [7:0] b,
                                                            logic [7:0] c, logic [7:0] d,
                                                            int unsigned wx, int unsigned wy);
      longint unsigned s, top, bot, v;
      s = 1 << WBITS;
      top = a * (s - wx) + b * wx;
      bot = c * (s - wx) + d * wx;
      v = top * (s - wy) + bot * wy + (longint'(1) << (2 * WBITS - 1));
      return cbrs_pkg::CHAN_W'(v >> (2 * WBITS));
   endfunction

   // advance the scaler by one source pixel and queue the destination pixels
   function automatic void scale_pixel(src_beat_type beat);
      int unsigned x, y, nr, nc, first;
      logic [cbrs_pkg::PIXEL_W-1:0] cur, above, p00, p01, p10;
      axis_type ra[2], ca[2], a;
      int unsigned rdy[2], cdx[2];
      dst_pixel_type px;
      if (beat.fb) begin
         latch_geometry(1'b1);
         src_col = 0;
         src_row = 0;
         dst_col_cnt = 0;
         dst_row_cnt = 0;
      end
      x = src_col;
      y = src_row;
      cur = expand_rgb(beat.word);
      above = line_mem[x % LINE_MAX];
      nr = 0;
      nc = 0;
      for (int i = 0; i < 2; i++) begin
         if (dst_row_cnt + i >= geo_th) break;
         a = split_pos(row_pos + i * row_step, geo_sh);
         if (a.trig > y) break;
         ra[i] = a;
         rdy[i] = dst_row_cnt + i;
         nr++;
      end
      for (int j = 0; j < 2; j++) begin
         if (dst_col_cnt + j >= geo_tw) break;
         a = split_pos(col_pos + j * col_step, geo_sw);
         if (a.trig > x) break;
         ca[j] = a;
         cdx[j] = dst_col_cnt + j;
         nc++;
      end
      first = pixel_expect_q.size();
      for (int i = 0; i < nr; i++) begin
         for (int j = 0; j < nc; j++) begin
            p10 = ca[j].single ? cur : current_left;
            if (ra[i].single) begin
               p00 = p10;
               p01 = cur;
            end else begin
               p00 = ca[j].single ? above : above_left;
               p01 = above;
            end
            px.red   = mix_chan(p00[23:16], p01[23:16], p10[23:16], cur[23:16],
                                ca[j].wt, ra[i].wt);
            px.green = mix_chan(p00[15:8], p01[15:8], p10[15:8], cur[15:8],
                                ca[j].wt, ra[i].wt);
            px.blue  = mix_chan(p00[7:0], p01[7:0], p10[7:0], cur[7:0],
                                ca[j].wt, ra[i].wt);
            px.col = cbrs_pkg::COORD_W'(cdx[j]);
            px.row = cbrs_pkg::COORD_W'(rdy[i]);
            px.last = 1'b0;
            pixel_expect_q.push_back(px);
         end
      end
      if (pixel_expect_q.size() > first) pixel_expect_q[$].last = 1'b1;
      line_mem[x % LINE_MAX] = cur;
      above_left = above;
      current_left = cur;
      dst_col_cnt += nc;
      col_pos += nc * col_step;
      if (x + 1 >= geo_sw) begin
         dst_row_cnt += nr;
         row_pos += nr * row_step;
         dst_col_cnt = 0;
         col_pos = col_base;
         src_col = 0;
         if (y < geo_sh) src_row = y + 1;
      end else begin
         src_col = x + 1;
      end
   endfunction

   // input driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_pixel_word  <= pending_beats[0].word;
            req_frame_begin <= pending_beats[0].fb;
            void'(pending_beats.pop_front());
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver; a long hold-off is counted here
   int hold_left = 0, holds_served = 0;
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = holds_served + 1;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor and watchdog
   int quiet = 0;
   always @(posedge clock) begin
      dst_pixel_type want;
      req_taken <= req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         scale_pixel('{word: req_pixel_word, fb: req_frame_begin});
      if (!reset && rsp_valid && rsp_ready) begin
         if (pixel_expect_q.size() == 0) begin
            $error("unexpected beat col %0d row %0d", rsp_target_column, rsp_target_row);
            failed = 1'b1;
         end else begin
            want = pixel_expect_q.pop_front();
            if (rsp_red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_red);
               failed = 1'b1;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_green);
               failed = 1'b1;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
               failed = 1'b1;
            end
            if (rsp_target_column !== want.col) begin
               $error("target_column: expected %0d, got %0d", want.col, rsp_target_column);
               failed = 1'b1;
            end
            if (rsp_target_row !== want.row) begin
               $error("target_row: expected %0d, got %0d", want.row, rsp_target_row);
               failed = 1'b1;
            end
            if (rsp_last_of_run !== want.last) begin
               $error("last_of_run: expected %0d, got %0d", want.last, rsp_last_of_run);
               failed = 1'b1;
            end
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [cbrs_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== val) begin
         $error("register %0d readback: expected %0h, got %0h", idx, val, prdata);
         failed = 1'b1;
      end
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         cbrs_pkg::REG_SRC_W:  reg_sw = val[cbrs_pkg::DIM_REG_W-1:0];
         cbrs_pkg::REG_SRC_H:  reg_sh = val[cbrs_pkg::DIM_REG_W-1:0];
         cbrs_pkg::REG_FORMAT: reg_fmt = val[cbrs_pkg::FMT_REG_W-1:0];
         cbrs_pkg::REG_DST_W:  reg_tw = val[cbrs_pkg::DIM_REG_W-1:0];
         cbrs_pkg::REG_DST_H:  reg_th = val[cbrs_pkg::DIM_REG_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_geometry(int sw, int sh, logic [cbrs_pkg::FMT_REG_W-1:0] fmt,
                               int tw, int th);
      csr_write(cbrs_pkg::REG_SRC_W, sw);
      csr_write(cbrs_pkg::REG_SRC_H, sh);
      csr_write(cbrs_pkg::REG_FORMAT, 32'(fmt));
      csr_write(cbrs_pkg::REG_DST_W, tw);
      csr_write(cbrs_pkg::REG_DST_H, th);
   endtask

   // queue one frame of w*h pixels plus trailing pixels past the last line
   task automatic push_frame(int w, int h, int extra, bit noisy);
      src_beat_type b;
      int sel;
      for (int k = 0; k < w * h + extra; k++) begin
         sel = $urandom_range(7);
         b.word = (sel == 0) ? 24'h000000 : (sel == 1) ? 24'hffffff : 24'($urandom);
         b.fb = (k == 0) || (noisy && k > w && $urandom_range(99) == 0);
         pending_beats.push_back(b);
      end
   endtask

   task automatic drain();
      while (pending_beats.size() > 0 || req_valid) @(posedge clock);
      while (pixel_expect_q.size() > 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      int sw, sh, tw, th, n;
      above_left = '0;
      current_left = '0;
      src_col = 0;
      src_row = 0;
      dst_col_cnt = 0;
      dst_row_cnt = 0;
      latch_geometry(1'b0);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stream a few pixels before any frame start: reset steps of zero
      push_frame(5, 1, 0, 1'b0);
      pending_beats[0].fb = 1'b0;
      drain();
      set_geometry(3, 2, cbrs_pkg::FMT_565_LE, 2, 1);
      push_frame(3, 2, 0, 1'b0);
      drain();
      set_geometry(2, 2, cbrs_pkg::FMT_565_BE, 2, 2);
      push_frame(2, 2, 0, 1'b0);
      drain();
      set_geometry(2, 2, cbrs_pkg::FMT_RGB24, 1, 1);
      push_frame(2, 2, 0, 1'b0);
      drain();
      set_geometry(2, 1, 3, 1, 1);
      push_frame(2, 1, 0, 1'b0);
      drain();
      // zero dimensions count as one
      set_geometry(0, 0, cbrs_pkg::FMT_565_LE, 0, 0);
      push_frame(1, 1, 2, 1'b0);
      drain();
      // upscaling
      set_geometry(2, 2, cbrs_pkg::FMT_RGB24, 5, 3);
      push_frame(2, 2, 2, 1'b0);
      drain();

      while (rand_items < 330) begin
         if (rand_items < 110) begin
            send_idle_pct = 22;
            recv_idle_pct = 81;
         end else if (rand_items < 220) begin
            send_idle_pct = 81;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         sw = $urandom_range(1, 12);
         sh = $urandom_range(1, 8);
         tw = $urandom_range(1, sw);
         th = $urandom_range(1, sh);
         if ($urandom_range(9) == 0) tw = $urandom_range(1, 16);
         if ($urandom_range(9) == 0) th = $urandom_range(1, 10);
         set_geometry(sw, sh, cbrs_pkg::FMT_REG_W'($urandom_range(3)), tw, th);
         n = $urandom_range(1, 2);
         for (int f = 0; f < n; f++) begin
            push_frame(sw, sh, $urandom_range(3) == 0 ? $urandom_range(1, 4) : 0,
                       $urandom_range(4) == 0);
            rand_items += sw * sh;
         end
         if (rand_items > 230 && hold_requests == 0) hold_requests = 1;
         drain();
      end

      // widest line, clamped from the register maximum
      set_geometry(2047, 1, cbrs_pkg::FMT_565_BE, 1024, 1);
      push_frame(40, 1, 0, 1'b0);
      drain();
      set_geometry(3, 2047, cbrs_pkg::FMT_RGB24, 3, 2047);
      push_frame(3, 2, 0, 1'b0);
      drain();
      set_geometry(1024, 1024, cbrs_pkg::FMT_565_LE, 1024, 1024);
      push_frame(8, 1, 0, 1'b0);
      drain();

      if (!failed) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
design/cbrs_pkg.sv
design/crop_bilinear_rgb_scaler.sv
design/cbrs_check.sv
tb/tb_top.sv
